// File: src/pmcsr_pkg.sv
// Shared constants, codes and control types of the CSR row builder.
package pmcsr_pkg;

	localparam int MAX_DIM = 64;

	localparam int POS_W   = 6;
	localparam int SIZE_W  = 7;
	localparam int COUNT_W = 21;
	localparam int COL_W   = 18;
	localparam int COEF_W  = 4;
	localparam int DIAG_W  = 3;
	localparam int PLANE_W = 2 * SIZE_W;
	localparam int ROWOFF_W = POS_W + SIZE_W;
	localparam int NUM_SLOT = 7;
	localparam int SLOT_W  = 3;
	localparam int CFG_IDX_W = 2;

	localparam logic [COUNT_W-1:0] COUNT_CAP = COUNT_W'(7 * MAX_DIM * MAX_DIM * MAX_DIM);
	localparam logic [SIZE_W-1:0]  SIZE_RESET = SIZE_W'(64);
	localparam logic [DIAG_W-1:0]  DIAG_FULL = DIAG_W'(6);
	localparam logic signed [COEF_W-1:0] COEF_OFF = -4'sd1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SIZE_X = 2'd0,
		REG_SIZE_Y = 2'd1,
		REG_SIZE_Z = 2'd2,
		REG_NONE   = 2'd3
	} reg_idx_t;

	typedef enum logic [SLOT_W-1:0] {
		SLOT_MX   = 3'd0,
		SLOT_MY   = 3'd1,
		SLOT_MZ   = 3'd2,
		SLOT_DIAG = 3'd3,
		SLOT_PZ   = 3'd4,
		SLOT_PY   = 3'd5,
		SLOT_PX   = 3'd6,
		SLOT_NONE = 3'd7
	} slot_t;

	typedef struct packed {
		logic load;
		logic mul;
		logic sum;
		logic advance;
	} pmcsr_cmd_t;

	typedef struct packed {
		logic last;
	} pmcsr_sts_t;

endpackage

// File: src/pmcsr_if.sv
// Handshake interfaces for voxel items, CSR entry items and register writes.
interface pmcsr_voxel_if import pmcsr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              first_row;
	logic [POS_W-1:0]  x_pos;
	logic [POS_W-1:0]  y_pos;
	logic [POS_W-1:0]  z_pos;
	logic              center_fluid;
	logic              fluid_minus_x;
	logic              fluid_minus_y;
	logic              fluid_minus_z;
	logic              fluid_plus_z;
	logic              fluid_plus_y;
	logic              fluid_plus_x;

	modport source (output valid, first_row, x_pos, y_pos, z_pos, center_fluid,
		fluid_minus_x, fluid_minus_y, fluid_minus_z, fluid_plus_z, fluid_plus_y,
		fluid_plus_x, input ready);
	modport sink (input valid, first_row, x_pos, y_pos, z_pos, center_fluid,
		fluid_minus_x, fluid_minus_y, fluid_minus_z, fluid_plus_z, fluid_plus_y,
		fluid_plus_x, output ready);
endinterface

interface pmcsr_entry_if import pmcsr_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [COUNT_W-1:0]        row_start;
	logic                      has_entry;
	logic [COL_W-1:0]          column;
	logic signed [COEF_W-1:0]  coefficient;
	logic                      last_of_row;

	modport source (output valid, row_start, has_entry, column, coefficient, last_of_row,
		input ready);
	modport sink (input valid, row_start, has_entry, column, coefficient, last_of_row,
		output ready);
endinterface

interface pmcsr_cfg_if import pmcsr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [SIZE_W-1:0]    data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// File: src/pmcsr_ctrl.sv
// Sequencer: accept a voxel, run the two index steps, then hand out its entries.
module pmcsr_ctrl import pmcsr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  pmcsr_sts_t sts,
	output pmcsr_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   in_ready_q;
	logic   out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd.load    = in_valid & in_ready_q;
		cmd.mul     = (state_q == ST_MUL);
		cmd.sum     = (state_q == ST_SUM);
		cmd.advance = out_valid_q & out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_ready_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= ST_MUL;
						in_ready_q <= 1'b0;
					end
				end
				ST_MUL: begin
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q     <= ST_EMIT;
					out_valid_q <= 1'b1;
				end
				ST_EMIT: begin
					if (out_ready && sts.last) begin
						state_q     <= ST_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: begin
					state_q     <= ST_IDLE;
					out_valid_q <= 1'b0;
					in_ready_q  <= 1'b1;
				end
			endcase
		end
	end

endmodule

// File: src/pmcsr_dp.sv
// Datapath: size registers, nonzero count, column index arithmetic, entry selection.
module pmcsr_dp import pmcsr_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  pmcsr_cmd_t               cmd,
	output pmcsr_sts_t               sts,
	input  logic                     cfg_write,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [SIZE_W-1:0]        cfg_data,
	input  logic                     first_row,
	input  logic [POS_W-1:0]         x_pos,
	input  logic [POS_W-1:0]         y_pos,
	input  logic [POS_W-1:0]         z_pos,
	input  logic                     center_fluid,
	input  logic                     fluid_minus_x,
	input  logic                     fluid_minus_y,
	input  logic                     fluid_minus_z,
	input  logic                     fluid_plus_z,
	input  logic                     fluid_plus_y,
	input  logic                     fluid_plus_x,
	output logic [COUNT_W-1:0]       row_start,
	output logic                     has_entry,
	output logic [COL_W-1:0]         column,
	output logic signed [COEF_W-1:0] coefficient,
	output logic                     last_of_row
);

	logic [SIZE_W-1:0]   size_x_q, size_y_q, size_z_q;
	logic [COUNT_W-1:0]  count_q;
	logic [COUNT_W-1:0]  row_q;
	logic [POS_W-1:0]    x_q, y_q, z_q;
	logic [NUM_SLOT-1:0] mask_q;
	logic [DIAG_W-1:0]   diag_q;
	logic [PLANE_W-1:0]  plane_q;
	logic [ROWOFF_W-1:0] ysz_q;
	logic [COL_W-1:0]    base_q;

	logic                x_lo, y_lo, z_lo, x_hi, y_hi, z_hi;
	logic [DIAG_W-1:0]   faces;
	logic [DIAG_W-1:0]   diag;
	logic [NUM_SLOT-1:0] mask;
	logic [NUM_SLOT-1:0] sel;
	logic [SLOT_W-1:0]   idx;
	logic [COL_W-1:0]    col;
	logic [COL_W-1:0]    plane_ext;
	logic [COL_W-1:0]    sz_ext;

	always_comb begin
		x_lo  = (x_pos == '0);
		y_lo  = (y_pos == '0);
		z_lo  = (z_pos == '0);
		x_hi  = ({1'b0, x_pos} + SIZE_W'(1)) >= size_x_q;
		y_hi  = ({1'b0, y_pos} + SIZE_W'(1)) >= size_y_q;
		z_hi  = ({1'b0, z_pos} + SIZE_W'(1)) >= size_z_q;
		faces = DIAG_W'(x_lo) + DIAG_W'(x_hi) + DIAG_W'(y_lo)
			+ DIAG_W'(y_hi) + DIAG_W'(z_lo) + DIAG_W'(z_hi);
		diag  = DIAG_FULL - faces;
		mask[SLOT_MX]   = fluid_minus_x & ~x_lo;
		mask[SLOT_MY]   = fluid_minus_y & ~y_lo;
		mask[SLOT_MZ]   = fluid_minus_z & ~z_lo;
		mask[SLOT_DIAG] = (diag != '0);
		mask[SLOT_PZ]   = fluid_plus_z & ~z_hi;
		mask[SLOT_PY]   = fluid_plus_y & ~y_hi;
		mask[SLOT_PX]   = fluid_plus_x & ~x_hi;
		if (!center_fluid) begin
			mask = '0;
		end
	end

	always_comb begin
		sel = mask_q & (~mask_q + NUM_SLOT'(1));
		idx = SLOT_NONE;
		for (int i = NUM_SLOT - 1; i >= 0; i--) begin
			if (sel[i]) begin
				idx = SLOT_W'(i);
			end
		end
		plane_ext = COL_W'(plane_q);
		sz_ext    = COL_W'(size_z_q);
		case (idx)
			SLOT_MX: col = base_q - plane_ext;
			SLOT_MY: col = base_q - sz_ext;
			SLOT_MZ: col = base_q - COL_W'(1);
			SLOT_PZ: col = base_q + COL_W'(1);
			SLOT_PY: col = base_q + sz_ext;
			SLOT_PX: col = base_q + plane_ext;
			default: col = base_q;
		endcase
	end

	assign row_start   = row_q;
	assign has_entry   = (mask_q != '0);
	assign column      = has_entry ? col : '0;
	assign coefficient = !has_entry ? '0 :
		(idx == SLOT_DIAG) ? $signed({1'b0, diag_q}) : COEF_OFF;
	assign last_of_row = ((mask_q & ~sel) == '0);
	assign sts.last    = last_of_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_x_q <= SIZE_RESET;
			size_y_q <= SIZE_RESET;
			size_z_q <= SIZE_RESET;
			count_q  <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_index)
					REG_SIZE_X: size_x_q <= cfg_data;
					REG_SIZE_Y: size_y_q <= cfg_data;
					REG_SIZE_Z: size_z_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.load && first_row) begin
				count_q <= '0;
			end else if (cmd.advance && has_entry && (count_q < COUNT_CAP)) begin
				count_q <= count_q + COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q    <= x_pos;
			y_q    <= y_pos;
			z_q    <= z_pos;
			mask_q <= mask;
			diag_q <= diag;
			row_q  <= first_row ? '0 : count_q;
		end else if (cmd.advance) begin
			mask_q <= mask_q & ~sel;
		end
		if (cmd.mul) begin
			plane_q <= PLANE_W'(size_y_q) * PLANE_W'(size_z_q);
			ysz_q   <= ROWOFF_W'(y_q) * ROWOFF_W'(size_z_q);
		end
		if (cmd.sum) begin
			base_q <= COL_W'(x_q) * COL_W'(plane_q) + COL_W'(ysz_q) + COL_W'(z_q);
		end
	end

endmodule

// File: src/poisson_matrix_csr_row_builder_core.sv
// Top level of the seven-point Poisson CSR row builder.
// The first entry item is valid once the multiply and sum states have run after acceptance.
// A new voxel is accepted only after the last of the previous voxel's n = 1..7 entry items,
// handed out one per cycle while the entry side holds ready high, has been taken.
// The sequencer runs its two index steps (plane product, then column base) before emitting.
// Reset: asynchronous, active low; clears the nonzero count, sets sizes to 64, goes idle.
module poisson_matrix_csr_row_builder_core import pmcsr_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	pmcsr_voxel_if.sink   voxel,
	pmcsr_entry_if.source entry,
	pmcsr_cfg_if.sink     cfg
);

	pmcsr_cmd_t cmd;
	pmcsr_sts_t sts;

	assign cfg.ready = 1'b1;

	pmcsr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (voxel.valid),
		.in_ready  (voxel.ready),
		.out_valid (entry.valid),
		.out_ready (entry.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	pmcsr_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_write     (cfg.valid),
		.cfg_index     (cfg.index),
		.cfg_data      (cfg.data),
		.first_row     (voxel.first_row),
		.x_pos         (voxel.x_pos),
		.y_pos         (voxel.y_pos),
		.z_pos         (voxel.z_pos),
		.center_fluid  (voxel.center_fluid),
		.fluid_minus_x (voxel.fluid_minus_x),
		.fluid_minus_y (voxel.fluid_minus_y),
		.fluid_minus_z (voxel.fluid_minus_z),
		.fluid_plus_z  (voxel.fluid_plus_z),
		.fluid_plus_y  (voxel.fluid_plus_y),
		.fluid_plus_x  (voxel.fluid_plus_x),
		.row_start     (entry.row_start),
		.has_entry     (entry.has_entry),
		.column        (entry.column),
		.coefficient   (entry.coefficient),
		.last_of_row   (entry.last_of_row)
	);

endmodule
